>>> hw/rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  // Operation codes carried on the input tuser field
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Bytes with a meaning of their own
  localparam logic [7:0] BYTE_END      = 8'h00;
  localparam logic [7:0] BYTE_COLOR    = 8'h01;
  localparam logic [7:0] BYTE_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] COLOR_DEFAULT = 8'h07;

  // Field widths of the stream words
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 40;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;       // latch the incoming word
    logic set_color;    // take the byte as the current colour
    logic set_pend;     // a colour byte follows
    logic newline;      // cursor to the start of the next row
    logic col_inc;      // cursor one column on
    logic char_write;   // store the byte at the cursor
    logic read_issue;   // read the requested cell
    logic home;         // cursor to the top left corner
    logic sweep_clr;    // sweep counter to zero
    logic sweep_inc;    // sweep counter one on
    logic sweep_move;   // sweep counter to the first cell of the bottom row
    logic fill_write;   // write the fill value at the sweep address
    logic fill_zero;    // fill value is zero rather than a coloured space
    logic scroll_step;  // read one cell a row below and queue its copy
    logic out_load;     // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       byte_end;
    logic       byte_color;
    logic       byte_nl;
    logic       pend;
    logic       col_last;
    logic       row_last;
    logic       sweep_move_last;
    logic       sweep_cell_last;
    logic       wr_pending;
    logic       out_free;
  } sts_t;

endpackage

>>> hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_SDRAIN = 3'd4;
  localparam logic [2:0] ST_ZFILL  = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // A new word is taken when idle, or as the previous result leaves
  assign in_tready = (state_r == ST_IDLE) || ((state_r == ST_RESP) && sts.out_free);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        priority case (sts.op)
          tcw_pkg::OP_WRITE: begin
            priority if (sts.pend) begin
              cmd.set_color = 1'b1;
            end else if (sts.byte_end) begin
              // String end: nothing changes
            end else if (sts.byte_color) begin
              cmd.set_pend = 1'b1;
            end else if (sts.byte_nl) begin
              cmd.newline = 1'b1;
              if (sts.row_last) begin
                cmd.sweep_clr = 1'b1;
                state_nxt     = ST_SCROLL;
              end
            end else begin
              cmd.char_write = 1'b1;
              if (sts.col_last) begin
                cmd.newline = 1'b1;
                if (sts.row_last) begin
                  cmd.sweep_clr = 1'b1;
                  state_nxt     = ST_SCROLL;
                end
              end else begin
                cmd.col_inc = 1'b1;
              end
            end
          end
          tcw_pkg::OP_CLEAR: begin
            cmd.home      = 1'b1;
            cmd.sweep_clr = 1'b1;
            state_nxt     = ST_CLEAR;
          end
          tcw_pkg::OP_READ: begin
            cmd.read_issue = 1'b1;
          end
          default: begin
            // Unused opcode: result only
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.fill_write = 1'b1;
        cmd.sweep_inc  = 1'b1;
        if (sts.sweep_cell_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        cmd.sweep_inc   = 1'b1;
        if (sts.sweep_move_last) begin
          state_nxt = ST_SDRAIN;
        end
      end
      ST_SDRAIN: begin
        // The last copied cell is written here
        cmd.sweep_move = 1'b1;
        state_nxt      = ST_ZFILL;
      end
      ST_ZFILL: begin
        cmd.fill_write = 1'b1;
        cmd.fill_zero  = 1'b1;
        cmd.sweep_inc  = 1'b1;
        if (sts.sweep_cell_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (in_tvalid) begin
            cmd.accept = 1'b1;
            state_nxt  = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/tcw_dp.sv
// Datapath of the text console writer: cursor, colour, screen RAM and result register.
module tcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tcw_pkg::IN_W-1:0]    in_tdata,
  input  logic [tcw_pkg::OP_W-1:0]    in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tcw_pkg::OUT_W-1:0]   out_tdata,
  input  tcw_pkg::cmd_t               cmd,
  output tcw_pkg::sts_t               sts
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);

  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [AW-1:0] MOVE_A      = AW'(MOVE_CELLS);
  localparam logic [AW-1:0] MOVE_LAST_A = AW'(MOVE_CELLS - 1);
  localparam logic [AW-1:0] CELL_LAST_A = AW'(CELL_COUNT - 1);
  localparam logic [tcw_pkg::COL_W-1:0] COL_LAST = tcw_pkg::COL_W'(COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST = tcw_pkg::ROW_W'(ROWS - 1);
  localparam logic [12:0] CELL_COUNT_W = 13'(CELL_COUNT);

  // Latched input word
  logic [tcw_pkg::OP_W-1:0]   op_r;
  logic [tcw_pkg::BYTE_W-1:0] byte_r;
  logic [tcw_pkg::BYTE_W-1:0] fill_r;
  logic [tcw_pkg::IDX_W-1:0]  idx_r;

  // Console state
  logic [tcw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [tcw_pkg::BYTE_W-1:0] color_r, color_nxt;
  logic                       pend_r, pend_nxt;

  // Sweep and scroll copy stage
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic          wr_valid_r;
  logic [AW-1:0] wr_addr_r;

  // Result register
  logic                      out_valid_r;
  logic [tcw_pkg::OUT_W-1:0] out_data_r;

  // RAM ports
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]              cursor_addr;
  logic [tcw_pkg::CELL_W-1:0] cell_out;
  logic                       in_range;

  // Input word capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_tuser;
      byte_r <= in_tdata[7:0];
      fill_r <= in_tdata[15:8];
      idx_r  <= in_tdata[26:16];
    end
  end

  // Cursor, colour and pending flag
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    color_nxt = color_r;
    pend_nxt  = pend_r;
    priority if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cmd.newline) begin
      col_nxt = '0;
      if (row_r != ROW_LAST) begin
        row_nxt = row_r + 1'b1;
      end
    end else if (cmd.col_inc) begin
      col_nxt = col_r + 1'b1;
    end
    if (cmd.set_color) begin
      color_nxt = byte_r;
      pend_nxt  = 1'b0;
    end else if (cmd.set_pend) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      color_r <= tcw_pkg::COLOR_DEFAULT;
      pend_r  <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      color_r <= color_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Sweep counter
  always_comb begin
    sweep_nxt = sweep_r;
    priority if (cmd.sweep_clr) begin
      sweep_nxt = '0;
    end else if (cmd.sweep_move) begin
      sweep_nxt = MOVE_A;
    end else if (cmd.sweep_inc) begin
      sweep_nxt = sweep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sweep_r <= sweep_nxt;
  end

  // Scroll copy: the cell read one row below is written in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else begin
      wr_valid_r <= cmd.scroll_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scroll_step) begin
      wr_addr_r <= sweep_r;
    end
  end

  // RAM port selection
  assign cursor_addr = AW'(row_r) * COLS_A + AW'(col_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_r;
    ram_wdata = '0;
    priority if (wr_valid_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_r;
      ram_wdata = ram_rdata;
    end else if (cmd.char_write) begin
      ram_we    = 1'b1;
      ram_waddr = cursor_addr;
      ram_wdata = {color_r, byte_r};
    end else if (cmd.fill_write) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = cmd.fill_zero ? '0 : {fill_r, tcw_pkg::CHAR_SPACE};
    end
  end

  assign ram_re    = cmd.scroll_step || cmd.read_issue;
  assign ram_raddr = cmd.scroll_step ? (sweep_r + COLS_A) : AW'(idx_r);

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result word
  assign in_range = ({2'b00, idx_r} < CELL_COUNT_W);
  assign cell_out = ((op_r == tcw_pkg::OP_READ) && in_range) ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {4'b0000, color_r, row_r, col_r, cell_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller
  assign sts.op              = op_r;
  assign sts.byte_end        = (byte_r == tcw_pkg::BYTE_END);
  assign sts.byte_color      = (byte_r == tcw_pkg::BYTE_COLOR);
  assign sts.byte_nl         = (byte_r == tcw_pkg::BYTE_NEWLINE);
  assign sts.pend            = pend_r;
  assign sts.col_last        = (col_r == COL_LAST);
  assign sts.row_last        = (row_r == ROW_LAST);
  assign sts.sweep_move_last = (sweep_r == MOVE_LAST_A);
  assign sts.sweep_cell_last = (sweep_r == CELL_LAST_A);
  assign sts.wr_pending      = wr_valid_r;
  assign sts.out_free        = !out_valid_r || out_tready;

endmodule

>>> hw/rtl/text_console_writer_top.sv
// Top level of the text console writer: controller, datapath and checks.
//
// Channel  Direction  Handshake              Contents
// in_      slave      in_tvalid / in_tready   one console command word
// out_     master     out_tvalid / out_tready cell read back, cursor and colour
//
// A write, read or unused opcode passes through the execute and result states;
// the next word is taken as the result is loaded. A clear is bound by the single
// RAM write port sweeping every cell. A newline below the bottom row scrolls:
// one copy per cycle through the RAM, then the zero fill of the bottom row.
// Reset is synchronous and active low; it clears cursor and flags, restores the
// default colour and keeps the screen RAM. A stalled result holds the block in
// its result state; input is not taken while a sweep runs.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [7:0] text_byte, [15:8] fill_color, [26:16] cell_index, [31:27] zero
  input  logic [tcw_pkg::IN_W-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [tcw_pkg::OP_W-1:0]  in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [15:0] cell_value, [22:16] cursor_column, [27:23] cursor_row,
  // [35:28] color_now, [39:36] zero
  output logic [tcw_pkg::OUT_W-1:0] out_tdata
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  // Controller
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // A character store never meets a queued scroll copy on the write port
  a_char_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.char_write |-> !sts.wr_pending)
    else $error("character write collides with scroll copy");

  // A fill write never meets a queued scroll copy either
  a_fill_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_write |-> !sts.wr_pending)
    else $error("fill write collides with scroll copy");

  // Only one word is in work at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while one is in work");

  // The reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[27:23] <= tcw_pkg::ROW_W'(ROWS - 1))
                    && (out_tdata[22:16] <= tcw_pkg::COL_W'(COLUMNS - 1))))
    else $error("cursor reported off the screen");

endmodule
